/* hdl/lavm_pkg.sv */
package lavm_pkg;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
    } t_in;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] row_x;
        logic signed [31:0] row_y;
        logic signed [31:0] row_z;
        logic signed [31:0] row_w;
        logic               degenerate;
        logic               last_row;
    } t_out;

    // work item held between front and back: eye, up and target - eye
    typedef struct packed {
        logic [2:0][31:0] eye;
        logic [2:0][31:0] up;
        logic [2:0][32:0] d;
    } t_work;

    // finished matrix handed to the row emitter
    typedef struct packed {
        logic [2:0][31:0] s;
        logic [2:0][31:0] u;
        logic [2:0][31:0] f;
        logic [31:0]      ds;
        logic [31:0]      du;
        logic [31:0]      df;
        logic             degen;
    } t_mat;

    localparam int LastRow = 3;

endpackage

/* hdl/lavm_front.sv */
module lavm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lavm_pkg::t_in        i_in_data,
    output logic                 o_q_valid,
    output lavm_pkg::t_work      o_q_data,
    input  logic                 i_q_pop
);
    import lavm_pkg::*;

    t_work       r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        push;
    t_work       item;

    assign o_in_stall = (r_cnt == 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_data   = r_q[r_rp];
    assign push       = i_in_valid && !o_in_stall;

    always_comb begin
        item.eye[0] = i_in_data.eye_x;
        item.eye[1] = i_in_data.eye_y;
        item.eye[2] = i_in_data.eye_z;
        item.up[0]  = i_in_data.up_x;
        item.up[1]  = i_in_data.up_y;
        item.up[2]  = i_in_data.up_z;
        item.d[0]   = {i_in_data.target_x[31], i_in_data.target_x}
                    - {i_in_data.eye_x[31], i_in_data.eye_x};
        item.d[1]   = {i_in_data.target_y[31], i_in_data.target_y}
                    - {i_in_data.eye_y[31], i_in_data.eye_y};
        item.d[2]   = {i_in_data.target_z[31], i_in_data.target_z}
                    - {i_in_data.eye_z[31], i_in_data.eye_z};
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, i_q_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hdl/lavm_norm.sv */
module lavm_norm #(
    parameter int FRAC_BITS = 16,
    parameter int W_V       = 53
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [2:0][W_V-1:0]              i_vec,
    output logic                             o_done,
    output logic [2:0][FRAC_BITS+2:0]        o_res,
    output logic                             o_zero
);
    import lavm_pkg::*;

    localparam int W_N = 31 + FRAC_BITS;
    localparam int W_C = $clog2(FRAC_BITS + 1);
    localparam logic [W_V-1:0] TH38 = W_V'(1) << 38;
    localparam logic [W_V-1:0] TH30 = W_V'(1) << 30;
    localparam logic [W_V-1:0] TH29 = W_V'(1) << 29;
    localparam logic [W_V-1:0] TH21 = W_V'(1) << 21;

    typedef enum logic [6:0] {
        N_IDLE  = 7'b0000001,
        N_SHIFT = 7'b0000010,
        N_SQ    = 7'b0000100,
        N_ROOT  = 7'b0001000,
        N_DINIT = 7'b0010000,
        N_DIV   = 7'b0100000,
        N_DONE  = 7'b1000000
    } t_nstate;

    t_nstate                 r_state;
    logic [2:0][W_V-1:0]     r_mag;
    logic [2:0]              r_neg;
    logic [W_V-1:0]          r_m;
    logic                    r_zero;
    logic [1:0]              r_sc;
    logic [59:0]             r_sq;
    logic [63:0]             r_n;
    logic [63:0]             r_res;
    logic [63:0]             r_bit;
    logic [30:0]             r_len;
    logic [2:0][30:0]        r_rem;
    logic [2:0][FRAC_BITS:0] r_q;
    logic [W_C-1:0]          r_cnt;

    logic [2:0][W_V-1:0]     in_mag;
    logic [W_V-1:0]          in_m01;
    logic [W_V-1:0]          in_m;
    logic [63:0]             root_t;
    logic [W_N-1:0]          dvd [3];
    logic [31:0]             div_t [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_mag[k] = i_vec[k][W_V-1] ? (~i_vec[k] + W_V'(1)) : i_vec[k];
        end
        in_m01 = (in_mag[0] > in_mag[1]) ? in_mag[0] : in_mag[1];
        in_m   = (in_m01 > in_mag[2]) ? in_m01 : in_mag[2];
        root_t = r_res + r_bit;
        for (int k = 0; k < 3; k++) begin
            dvd[k]   = {r_mag[k][29:0], {FRAC_BITS{1'b0}}, 1'b0} >> 1;
            dvd[k]   = dvd[k] + W_N'(r_res[30:1]);
            div_t[k] = {r_rem[k], r_q[k][FRAC_BITS]};
        end
    end

    assign o_done = (r_state == N_DONE);
    assign o_zero = r_zero;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_res[k] = r_neg[k] ? (~{2'b00, r_q[k]} + (FRAC_BITS+3)'(1))
                                : {2'b00, r_q[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            unique case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        r_state <= (in_m == '0) ? N_DONE : N_SHIFT;
                    end
                end
                N_SHIFT: begin
                    if (r_m < TH30 && r_m >= TH29) begin
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    if (r_sc == 2'd3) begin
                        r_state <= N_ROOT;
                    end
                end
                N_ROOT: begin
                    if (r_bit[0]) begin
                        r_state <= N_DINIT;
                    end
                end
                N_DINIT: r_state <= N_DIV;
                N_DIV: begin
                    if (r_cnt == W_C'(FRAC_BITS)) begin
                        r_state <= N_DONE;
                    end
                end
                N_DONE:  r_state <= N_IDLE;
                default: r_state <= N_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            N_IDLE: begin
                if (i_start) begin
                    r_mag  <= in_mag;
                    r_m    <= in_m;
                    r_zero <= (in_m == '0);
                    r_q    <= '0;
                    r_sc   <= 2'd0;
                    for (int k = 0; k < 3; k++) begin
                        r_neg[k] <= i_vec[k][W_V-1];
                    end
                end
            end
            N_SHIFT: begin
                if (r_m >= TH38) begin
                    r_m <= r_m >> 8;
                    for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] >> 8;
                end else if (r_m >= TH30) begin
                    r_m <= r_m >> 1;
                    for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] >> 1;
                end else if (r_m < TH21) begin
                    r_m <= r_m << 8;
                    for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] << 8;
                end else if (r_m < TH29) begin
                    r_m <= r_m << 1;
                    for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] << 1;
                end
            end
            N_SQ: begin
                if (r_sc != 2'd3) begin
                    r_sq <= r_mag[r_sc][29:0] * r_mag[r_sc][29:0];
                end
                if (r_sc == 2'd0) begin
                    r_n <= '0;
                end else begin
                    r_n <= r_n + 64'(r_sq);
                end
                r_sc  <= r_sc + 2'd1;
                r_res <= '0;
                r_bit <= 64'(1) << 62;
            end
            N_ROOT: begin
                if (r_n >= root_t) begin
                    r_n   <= r_n - root_t;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            N_DINIT: begin
                r_len <= r_res[30:0];
                r_cnt <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_rem[k] <= 31'(dvd[k][W_N-1:FRAC_BITS+1]);
                    r_q[k]   <= dvd[k][FRAC_BITS:0];
                end
            end
            N_DIV: begin
                r_cnt <= r_cnt + W_C'(1);
                for (int k = 0; k < 3; k++) begin
                    if (div_t[k] >= {1'b0, r_len}) begin
                        r_rem[k] <= 31'(div_t[k] - {1'b0, r_len});
                        r_q[k]   <= {r_q[k][FRAC_BITS-1:0], 1'b1};
                    end else begin
                        r_rem[k] <= div_t[k][30:0];
                        r_q[k]   <= {r_q[k][FRAC_BITS-1:0], 1'b0};
                    end
                end
            end
            N_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

/* hdl/lavm_back.sv */
module lavm_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  lavm_pkg::t_work      i_q_data,
    output logic                 o_q_pop,
    input  logic                 i_out_busy,
    output logic                 o_load,
    output lavm_pkg::t_mat       o_mat
);
    import lavm_pkg::*;

    localparam int W_A   = FRAC_BITS + 3;
    localparam int W_P   = W_A + 32;
    localparam int W_ACC = FRAC_BITS + 37;
    localparam logic [4:0] OpLastCross = 5'd5;
    localparam logic [4:0] OpLast      = 5'd20;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_NF_GO   = 9'b000000010,
        S_NF_WAIT = 9'b000000100,
        S_CROSS   = 9'b000001000,
        S_CDRAIN  = 9'b000010000,
        S_NS_GO   = 9'b000100000,
        S_NS_WAIT = 9'b001000000,
        S_TAIL    = 9'b010000000,
        S_LOAD    = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {A_F, A_S, A_U} t_asel;
    typedef enum logic [1:0] {B_UP, B_F, B_EYE} t_bsel;
    typedef enum logic [1:0] {D_C, D_U, D_DOT} t_dst;

    typedef struct packed {
        t_asel      a;
        logic [1:0] ai;
        t_bsel      b;
        logic [1:0] bi;
        logic       sub;
        logic       first;
        logic       last;
        t_dst       dst;
        logic [1:0] di;
    } t_op;

    function automatic t_op op_decode(input logic [4:0] op);
        t_op d;
        d = '0;
        unique case (op)
            5'd0:  d = '{A_F, 2'd1, B_UP,  2'd2, 1'b0, 1'b1, 1'b0, D_C,   2'd0};
            5'd1:  d = '{A_F, 2'd2, B_UP,  2'd1, 1'b1, 1'b0, 1'b1, D_C,   2'd0};
            5'd2:  d = '{A_F, 2'd2, B_UP,  2'd0, 1'b0, 1'b1, 1'b0, D_C,   2'd1};
            5'd3:  d = '{A_F, 2'd0, B_UP,  2'd2, 1'b1, 1'b0, 1'b1, D_C,   2'd1};
            5'd4:  d = '{A_F, 2'd0, B_UP,  2'd1, 1'b0, 1'b1, 1'b0, D_C,   2'd2};
            5'd5:  d = '{A_F, 2'd1, B_UP,  2'd0, 1'b1, 1'b0, 1'b1, D_C,   2'd2};
            5'd6:  d = '{A_S, 2'd1, B_F,   2'd2, 1'b0, 1'b1, 1'b0, D_U,   2'd0};
            5'd7:  d = '{A_S, 2'd2, B_F,   2'd1, 1'b1, 1'b0, 1'b1, D_U,   2'd0};
            5'd8:  d = '{A_S, 2'd2, B_F,   2'd0, 1'b0, 1'b1, 1'b0, D_U,   2'd1};
            5'd9:  d = '{A_S, 2'd0, B_F,   2'd2, 1'b1, 1'b0, 1'b1, D_U,   2'd1};
            5'd10: d = '{A_S, 2'd0, B_F,   2'd1, 1'b0, 1'b1, 1'b0, D_U,   2'd2};
            5'd11: d = '{A_S, 2'd1, B_F,   2'd0, 1'b1, 1'b0, 1'b1, D_U,   2'd2};
            5'd12: d = '{A_S, 2'd0, B_EYE, 2'd0, 1'b0, 1'b1, 1'b0, D_DOT, 2'd0};
            5'd13: d = '{A_S, 2'd1, B_EYE, 2'd1, 1'b0, 1'b0, 1'b0, D_DOT, 2'd0};
            5'd14: d = '{A_S, 2'd2, B_EYE, 2'd2, 1'b0, 1'b0, 1'b1, D_DOT, 2'd0};
            5'd15: d = '{A_U, 2'd0, B_EYE, 2'd0, 1'b0, 1'b1, 1'b0, D_DOT, 2'd1};
            5'd16: d = '{A_U, 2'd1, B_EYE, 2'd1, 1'b0, 1'b0, 1'b0, D_DOT, 2'd1};
            5'd17: d = '{A_U, 2'd2, B_EYE, 2'd2, 1'b0, 1'b0, 1'b1, D_DOT, 2'd1};
            5'd18: d = '{A_F, 2'd0, B_EYE, 2'd0, 1'b0, 1'b1, 1'b0, D_DOT, 2'd2};
            5'd19: d = '{A_F, 2'd1, B_EYE, 2'd1, 1'b0, 1'b0, 1'b0, D_DOT, 2'd2};
            5'd20: d = '{A_F, 2'd2, B_EYE, 2'd2, 1'b0, 1'b0, 1'b1, D_DOT, 2'd2};
            default: d = '0;
        endcase
        return d;
    endfunction

    function automatic logic signed [W_ACC-1:0] round_fb(input logic signed [W_ACC-1:0] x);
        logic [W_ACC-1:0] mag;
        mag = x[W_ACC-1] ? (~x + W_ACC'(1)) : x;
        mag = (mag + (W_ACC'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return x[W_ACC-1] ? (~mag + W_ACC'(1)) : mag;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [W_ACC-1:0] x);
        logic signed [W_ACC-1:0] hi;
        logic signed [W_ACC-1:0] lo;
        hi = W_ACC'(32'sh7fffffff);
        lo = -(W_ACC'(32'sh7fffffff)) - W_ACC'(1);
        if (x > hi) begin
            return 32'h7fffffff;
        end else if (x < lo) begin
            return 32'h80000000;
        end
        return x[31:0];
    endfunction

    t_state                        r_state;
    t_work                         r_work;
    logic signed [W_A-1:0]         r_f [3];
    logic signed [W_A-1:0]         r_s [3];
    logic signed [W_A-1:0]         r_u [3];
    logic signed [W_ACC-1:0]       r_c [3];
    logic signed [W_ACC-1:0]       r_dot [3];
    logic                          r_degen;
    logic [4:0]                    r_op;
    logic                          r_pv;
    t_op                           r_pdec;
    logic signed [W_P-1:0]         r_prod;
    logic signed [W_ACC-1:0]       r_acc;

    t_op                           cur;
    logic                          issue;
    logic signed [W_A-1:0]         a_val;
    logic signed [31:0]            b_val;
    logic signed [W_ACC-1:0]       p_ext;
    logic signed [W_ACC-1:0]       acc_n;
    logic signed [W_ACC-1:0]       acc_r;
    logic                          n_start;
    logic [2:0][W_ACC-1:0]         n_vec;
    logic                          n_done;
    logic [2:0][W_A-1:0]           n_res;
    logic                          n_zero;

    assign cur     = op_decode(r_op);
    assign issue   = (r_state == S_CROSS) || (r_state == S_TAIL);
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign o_load  = (r_state == S_LOAD) && !i_out_busy && !r_pv;
    assign n_start = (r_state == S_NF_GO) || (r_state == S_NS_GO);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_state == S_NF_GO) begin
                n_vec[k] = W_ACC'($signed(r_work.d[k]));
            end else begin
                n_vec[k] = r_c[k];
            end
        end
    end

    lavm_norm #(
        .FRAC_BITS (FRAC_BITS),
        .W_V       (W_ACC)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_start),
        .i_vec   (n_vec),
        .o_done  (n_done),
        .o_res   (n_res),
        .o_zero  (n_zero)
    );

    always_comb begin
        case (cur.a)
            A_F:     a_val = r_f[cur.ai];
            A_S:     a_val = r_s[cur.ai];
            A_U:     a_val = r_u[cur.ai];
            default: a_val = '0;
        endcase
        case (cur.b)
            B_UP:    b_val = $signed(r_work.up[cur.bi]);
            B_F:     b_val = 32'(r_f[cur.bi]);
            B_EYE:   b_val = $signed(r_work.eye[cur.bi]);
            default: b_val = '0;
        endcase
        p_ext = W_ACC'(r_prod);
        acc_n = (r_pdec.first ? '0 : r_acc) + (r_pdec.sub ? -p_ext : p_ext);
        acc_r = round_fb(acc_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
        end else begin
            r_pv <= issue;
            unique case (r_state)
                S_IDLE:    if (i_q_valid) r_state <= S_NF_GO;
                S_NF_GO:   r_state <= S_NF_WAIT;
                S_NF_WAIT: if (n_done) r_state <= S_CROSS;
                S_CROSS:   if (r_op == OpLastCross) r_state <= S_CDRAIN;
                S_CDRAIN:  r_state <= S_NS_GO;
                S_NS_GO:   r_state <= S_NS_WAIT;
                S_NS_WAIT: if (n_done) r_state <= S_TAIL;
                S_TAIL:    if (r_op == OpLast) r_state <= S_LOAD;
                S_LOAD:    if (!i_out_busy && !r_pv) r_state <= S_IDLE;
                default:   r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_work <= i_q_data;
        end
        if (r_state == S_NF_WAIT && n_done) begin
            for (int k = 0; k < 3; k++) r_f[k] <= $signed(n_res[k]);
            r_degen <= n_zero;
            r_op    <= '0;
        end
        if (r_state == S_NS_WAIT && n_done) begin
            for (int k = 0; k < 3; k++) r_s[k] <= $signed(n_res[k]);
            r_degen <= r_degen | n_zero;
        end
        if (issue) begin
            r_prod <= a_val * b_val;
            r_pdec <= cur;
            r_op   <= r_op + 5'd1;
        end
        if (r_pv) begin
            r_acc <= acc_n;
            if (r_pdec.last) begin
                case (r_pdec.dst)
                    D_C:     r_c[r_pdec.di]   <= acc_n;
                    D_U:     r_u[r_pdec.di]   <= W_A'(acc_r);
                    D_DOT:   r_dot[r_pdec.di] <= acc_r;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_mat.s[k] = 32'(r_s[k]);
            o_mat.u[k] = 32'(r_u[k]);
            o_mat.f[k] = 32'(r_f[k]);
        end
        o_mat.ds    = sat32(-r_dot[0]);
        o_mat.du    = sat32(-r_dot[1]);
        o_mat.df    = sat32(r_dot[2]);
        o_mat.degen = r_degen;
    end

endmodule

/* hdl/lavm_out.sv */
module lavm_out #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  lavm_pkg::t_mat       i_mat,
    output logic                 o_busy,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lavm_pkg::t_out       o_out_data
);
    import lavm_pkg::*;

    t_mat        r_mat;
    logic        r_busy;
    logic [1:0]  r_row;
    logic        xfer;
    logic        last;

    assign o_busy      = r_busy;
    assign o_out_valid = r_busy;
    assign xfer        = r_busy && !i_out_stall;
    assign last        = (r_row == 2'(LastRow));

    always_comb begin
        o_out_data.row_index  = r_row;
        o_out_data.degenerate = r_mat.degen;
        o_out_data.last_row   = last;
        if (last) begin
            o_out_data.row_x = r_mat.ds;
            o_out_data.row_y = r_mat.du;
            o_out_data.row_z = r_mat.df;
            o_out_data.row_w = 32'(1) << FRAC_BITS;
        end else begin
            o_out_data.row_x = r_mat.s[r_row];
            o_out_data.row_y = r_mat.u[r_row];
            o_out_data.row_z = -r_mat.f[r_row];
            o_out_data.row_w = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mat <= i_mat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= 2'd0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_row  <= 2'd0;
        end else if (xfer) begin
            r_row <= r_row + 2'd1;
            if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

/* hdl/look_at_view_matrix.sv */
// channel   direction  handshake                      payload
// in        input      i_in_valid / o_in_stall        i_in_data  (lavm_pkg::t_in)
// out       output     o_out_valid / i_out_stall      o_out_data (lavm_pkg::t_out)
//
// Per item the back end runs two vector normalizations (a range-setting shift, three
// squares, 32-step square root, FRAC_BITS+1 step divide) plus 21 products through one
// shared multiplier. A two-entry queue takes items while the back end works; four rows
// then drain from the output stage, overlapping the next item. Output stalls hold the
// back end only once a finished matrix waits. Synchronous active-low reset clears the
// state machines, queue pointers, queue count, row counter, busy and product-valid flags.
module look_at_view_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lavm_pkg::t_in        i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lavm_pkg::t_out       o_out_data
);
    import lavm_pkg::*;

    logic   q_valid;
    t_work  q_data;
    logic   q_pop;
    logic   out_busy;
    logic   load;
    t_mat   mat;

    lavm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .o_q_data   (q_data),
        .i_q_pop    (q_pop)
    );

    lavm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_data),
        .o_q_pop    (q_pop),
        .i_out_busy (out_busy),
        .o_load     (load),
        .o_mat      (mat)
    );

    lavm_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_mat       (mat),
        .o_busy      (out_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
